// ===== sv/apl_pkg.sv =====
`default_nettype none
package apl_pkg;
   localparam logic [1:0] MODE_STATUS = 2'd0;
   localparam logic [1:0] MODE_TRADE  = 2'd1;
   localparam logic [1:0] MODE_MARK   = 2'd2;
   localparam logic [1:0] MODE_QUERY  = 2'd3;
   localparam logic [2:0] ST_RESTING   = 3'd1;
   localparam logic [2:0] ST_FILLED    = 3'd3;
   localparam logic [2:0] ST_CANCELLED = 3'd4;
   localparam logic [2:0] ST_REJECTED  = 3'd5;
   localparam logic [1:0] MUL_LO   = 2'd0;
   localparam logic [1:0] MUL_MID  = 2'd1;
   localparam logic [1:0] MUL_HIGH = 2'd2;

   // One row of the position table.
   typedef struct packed {
      logic [63:0] net;
      logic [31:0] cost;
      logic [63:0] realized;
      logic [63:0] unrealized;
      logic [31:0] last;
   } entry_type;

   function automatic logic [63:0] wabs(input logic [63:0] a);
      wabs = a[63] ? (64'd0 - a) : a;
   endfunction
endpackage
`default_nettype wire

// ===== sv/apl_mul.sv =====
`default_nettype none
// Shared multiplier: registered 32x32 product; the sequencer combines partials for wider products.
module apl_mul (
   input  wire logic        clock,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [63:0] prod_ff
);
   logic [63:0] prod_in;
   always_comb begin
      prod_in = {32'd0, a} * {32'd0, b};
   end
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

// ===== sv/apl_div.sv =====
`default_nettype none
// Restoring unsigned 64-bit divider, one quotient bit per cycle.
module apl_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             busy,
   output logic      [63:0] quot
);
   import apl_pkg::*;
   logic [63:0] q_ff, q_in, r_ff, r_in, d_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic [64:0] trial;
   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff;
      trial = {r_ff, q_ff[63]} - {1'b0, d_ff};
      if (start) begin
         q_in = num; r_in = 64'd0; cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         if (!trial[64]) r_in = trial[63:0];
         else r_in = {r_ff[62:0], q_ff[63]};
         q_in = {q_ff[62:0], ~trial[64]};
         cnt_in = cnt_ff - 7'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 7'd0;
      else cnt_ff <= cnt_in;
      q_ff <= q_in; r_ff <= r_in;
      if (start) d_ff <= den;
   end
   assign busy = (cnt_ff != 7'd0);
   assign quot = q_ff;
endmodule
`default_nettype wire

// ===== sv/avco_position_ledger_top.sv =====
`default_nettype none
// Status goes straight to the result; an open trade (flat entry) skips the multiplier; reducing
// trades and marks use it; an adding trade also uses the divider unless the new position is flat;
// a query walks every table entry on the shared 32x32 multiplier, plus a re-read of the slot.
// Throughput: one item at a time; req_ready rises the cycle after the result is taken.
// Reset: synchronous, clears control state, valid bits and the open-order count;
// table rows with a clear valid bit read as zero.
module avco_position_ledger_top #(
   parameter int NUM_SYMBOLS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [5:0]  req_symbol_index,
   input  wire logic [2:0]  req_order_status,
   input  wire logic        req_maker_side,
   input  wire logic        req_taker_is_own,
   input  wire logic [31:0] req_price,
   input  wire logic [31:0] req_quantity,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_entry_valid,
   output logic signed [63:0] rsp_net_qty,
   output logic [31:0]      rsp_average_cost,
   output logic signed [63:0] rsp_symbol_realized,
   output logic signed [63:0] rsp_symbol_unrealized,
   output logic [31:0]      rsp_open_orders,
   output logic signed [63:0] rsp_sum_realized,
   output logic signed [63:0] rsp_sum_unrealized,
   output logic signed [63:0] rsp_gross_notional
);
   import apl_pkg::*;
   localparam int AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

   localparam logic [4:0] S_IDLE = 5'd0, S_READ = 5'd1, S_DECIDE = 5'd2, S_M0 = 5'd3,
      S_M1 = 5'd4, S_M2 = 5'd5, S_M3 = 5'd6, S_DIV = 5'd7, S_DIVW = 5'd8,
      S_WRITE = 5'd9, S_OUT = 5'd10, S_QREAD = 5'd11, S_QM0 = 5'd12, S_QACC = 5'd13,
      S_FIN = 5'd14, S_QM1 = 5'd15, S_PQ = 5'd16, S_PQA = 5'd17;

   entry_type mem [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0] vld_ff;
   logic [4:0]  st_ff;
   logic [1:0]  mode_ff;
   logic [5:0]  sym_ff;
   logic [2:0]  stat_ff;
   logic        buy_ff, intab_ff;
   logic [31:0] price_ff, qty_ff, open_ff;
   entry_type   rd_ff, e_ff;
   logic        ev_ff;
   logic [AW:0] qi_ff;
   logic [63:0] acc_ff, t0_ff, tr_ff, tu_ff, tg_ff;
   logic [1:0]  mstep_ff;
   logic        rv_ff;

   logic [31:0] ma, mb;
   logic [63:0] mprod;
   apl_mul u_mul (.clock(clock), .a(ma), .b(mb), .prod_ff(mprod));

   logic        dstart, dbusy;
   logic [63:0] dquot, dnum, dden;
   apl_div u_div (.clock(clock), .reset(reset), .start(dstart), .num(dnum), .den(dden),
      .busy(dbusy), .quot(dquot));

   logic [AW-1:0] raddr, waddr;
   logic          rvalid_bit;
   logic          qwalk;
   assign waddr = AW'(sym_ff);
   assign qwalk = (st_ff == S_QREAD || st_ff == S_QM0 || st_ff == S_QM1 || st_ff == S_QACC);
   assign raddr = qwalk ? qi_ff[AW-1:0] : waddr;
   always_ff @(posedge clock) begin
      rd_ff <= mem[raddr];
      if (st_ff == S_WRITE && intab_ff) mem[waddr] <= e_ff;
   end
   assign rvalid_bit = vld_ff[raddr];

   // Decision flags for the fill.
   logic [63:0] fill, nq, old_abs, new_abs, closed, per_unit;
   logic        old_long, fill_long;
   always_comb begin
      fill = buy_ff ? {32'd0, qty_ff} : (64'd0 - {32'd0, qty_ff});
      nq = e_ff.net + fill;
      old_long = !e_ff.net[63];
      fill_long = buy_ff && (qty_ff != 32'd0);
      old_abs = wabs(e_ff.net);
      new_abs = wabs(nq);
      closed = ({32'd0, qty_ff} < old_abs && !old_abs[63]) ? {32'd0, qty_ff} : old_abs;
      per_unit = old_long ? ({32'd0, price_ff} - {32'd0, e_ff.cost})
                          : ({32'd0, e_ff.cost} - {32'd0, price_ff});
   end
   // Operands of the wide product a*b (64x64 low half), from up to three partials.
   logic [63:0] opa, opb;
   always_comb begin
      opa = 64'd0; opb = 64'd0;
      case (st_ff)
         S_QM0, S_QM1, S_QACC: begin opa = wabs(rd_ff.net); opb = {32'd0, rd_ff.last}; end
         S_PQ: begin opa = {32'd0, price_ff}; opb = {32'd0, qty_ff}; end
         default: begin
            if (mode_ff == MODE_MARK) begin
               opa = {32'd0, price_ff} - {32'd0, e_ff.cost}; opb = e_ff.net;
            end else if (old_long == fill_long) begin
               opa = {32'd0, e_ff.cost}; opb = old_abs;
            end else begin
               opa = per_unit; opb = closed;
            end
         end
      endcase
      case (mstep_ff)
         MUL_LO:  begin ma = opa[31:0];  mb = opb[31:0];  end
         MUL_MID: begin ma = opa[63:32]; mb = opb[31:0];  end
         default: begin ma = opa[31:0];  mb = opb[63:32]; end
      endcase
   end

   logic [63:0] sdiv;
   assign dnum = wabs(t0_ff);
   assign dden = new_abs;
   assign sdiv = (t0_ff[63] != dden[63]) ? (64'd0 - dquot) : dquot;
   assign dstart = (st_ff == S_DIV);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; vld_ff <= '0; open_ff <= 32'd0; rv_ff <= 1'b0; qi_ff <= '0;
         mstep_ff <= MUL_LO;
      end else begin
         case (st_ff)
            S_IDLE: if (req_valid && req_ready) begin
               mode_ff <= req_mode; sym_ff <= req_symbol_index; stat_ff <= req_order_status;
               buy_ff <= ~(req_taker_is_own ^ req_maker_side);
               price_ff <= req_price; qty_ff <= req_quantity;
               intab_ff <= ({26'd0, req_symbol_index} < 32'(NUM_SYMBOLS));
               tr_ff <= 64'd0; tu_ff <= 64'd0; tg_ff <= 64'd0; qi_ff <= '0;
               st_ff <= S_READ;
            end
            S_READ: st_ff <= S_DECIDE;
            S_DECIDE: begin
               ev_ff <= intab_ff && rvalid_bit;
               e_ff <= (intab_ff && rvalid_bit) ? rd_ff : '0;
               mstep_ff <= MUL_LO;
               case (mode_ff)
                  MODE_STATUS: begin
                     if (stat_ff == ST_RESTING) open_ff <= open_ff + 32'd1;
                     else if ((stat_ff == ST_FILLED || stat_ff == ST_CANCELLED ||
                               stat_ff == ST_REJECTED) && open_ff != 32'd0)
                        open_ff <= open_ff - 32'd1;
                     st_ff <= S_OUT;
                  end
                  MODE_TRADE: st_ff <= intab_ff ? S_M0 : S_OUT;
                  MODE_MARK: st_ff <= (intab_ff && rvalid_bit) ? S_M0 : S_OUT;
                  default: st_ff <= S_QREAD;
               endcase
            end
            S_M0: begin
               if (mode_ff == MODE_TRADE && e_ff.net == 64'd0) begin
                  e_ff.net <= nq; e_ff.cost <= price_ff; st_ff <= S_WRITE;
               end else begin
                  mstep_ff <= MUL_MID; st_ff <= S_M1;
               end
            end
            S_M1: begin acc_ff <= mprod; mstep_ff <= MUL_HIGH; st_ff <= S_M2; end
            S_M2: begin acc_ff <= acc_ff + {mprod[31:0], 32'd0}; st_ff <= S_M3; end
            S_M3: begin
               if (mode_ff == MODE_MARK) begin
                  e_ff.last <= price_ff;
                  e_ff.unrealized <= acc_ff + {mprod[31:0], 32'd0};
                  st_ff <= S_WRITE;
               end else if (old_long == fill_long) begin
                  t0_ff <= acc_ff + {mprod[31:0], 32'd0};
                  mstep_ff <= MUL_LO;
                  st_ff <= S_PQ;
               end else begin
                  e_ff.realized <= e_ff.realized + acc_ff + {mprod[31:0], 32'd0};
                  e_ff.net <= nq;
                  if (nq == 64'd0) e_ff.cost <= 32'd0;
                  else if (fill_long == !nq[63]) e_ff.cost <= price_ff;
                  st_ff <= S_WRITE;
               end
            end
            S_PQ: st_ff <= S_PQA;
            S_PQA: begin t0_ff <= t0_ff + mprod; st_ff <= S_DIV; end
            S_DIV: begin
               if (new_abs == 64'd0) begin
                  e_ff.net <= nq; st_ff <= S_WRITE;
               end else st_ff <= S_DIVW;
            end
            S_DIVW: if (!dbusy) begin
               e_ff.net <= nq; e_ff.cost <= sdiv[31:0]; st_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (mode_ff == MODE_TRADE) begin vld_ff[waddr] <= 1'b1; ev_ff <= 1'b1; end
               st_ff <= S_OUT;
            end
            S_QREAD: st_ff <= S_QM0;
            S_QM0: begin
               ev_ff <= rvalid_bit; mstep_ff <= MUL_MID; st_ff <= S_QM1;
            end
            S_QM1: begin acc_ff <= mprod; st_ff <= S_QACC; end
            S_QACC: begin
               // The last price has no upper half, so two partials give |net| times price.
               if (ev_ff) begin
                  tr_ff <= tr_ff + rd_ff.realized; tu_ff <= tu_ff + rd_ff.unrealized;
                  tg_ff <= tg_ff + acc_ff + {mprod[31:0], 32'd0};
               end
               mstep_ff <= MUL_LO;
               if (qi_ff == (AW+1)'(NUM_SYMBOLS - 1)) st_ff <= S_FIN;
               else begin qi_ff <= qi_ff + (AW+1)'(1); st_ff <= S_QREAD; end
            end
            S_FIN: begin sym_ff <= sym_ff; st_ff <= S_READ; mode_ff <= MODE_STATUS;
               stat_ff <= 3'd0; end
            S_OUT: begin rv_ff <= 1'b1; st_ff <= S_IDLE; end
            default: st_ff <= S_IDLE;
         endcase
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
      end
   end

   logic        qdone_ff;
   always_ff @(posedge clock) begin
      if (reset) qdone_ff <= 1'b0;
      else if (st_ff == S_FIN) qdone_ff <= 1'b1;
      else if (st_ff == S_IDLE && req_valid && req_ready) qdone_ff <= 1'b0;
   end

   assign req_ready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_entry_valid = ev_ff;
   assign rsp_net_qty = ev_ff ? e_ff.net : 64'd0;
   assign rsp_average_cost = ev_ff ? e_ff.cost : 32'd0;
   assign rsp_symbol_realized = ev_ff ? e_ff.realized : 64'd0;
   assign rsp_symbol_unrealized = ev_ff ? e_ff.unrealized : 64'd0;
   assign rsp_open_orders = open_ff;
   assign rsp_sum_realized = qdone_ff ? tr_ff : 64'd0;
   assign rsp_sum_unrealized = qdone_ff ? tu_ff : 64'd0;
   assign rsp_gross_notional = qdone_ff ? tg_ff : 64'd0;
endmodule
`default_nettype wire

// ===== sv/apl_checker.sv =====
`default_nettype none
module apl_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_entry_valid,
   input wire logic [63:0] rsp_net_qty
);
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("item accepted with result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_net_qty == 64'd0)
      else $error("invalid entry nonzero");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");
endmodule
bind avco_position_ledger_top apl_checker u_apl_checker (.clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_entry_valid(rsp_entry_valid),
   .rsp_net_qty(rsp_net_qty));
`default_nettype wire
